// ===== design/brd_pkg.sv =====
// Shared types and opcodes for the bounded record deque.
// No dependencies; used by brd_cell, brd_ctrl and bounded_record_deque.
`timescale 1ns / 1ps

package brd_pkg;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_RM_HEAD  = 3'd2,
    OP_RM_TAIL  = 3'd3,
    OP_RD_HEAD  = 3'd4,
    OP_RD_TAIL  = 3'd5,
    OP_RD_INDEX = 3'd6,
    OP_SIZE     = 3'd7
  } op_e;

  localparam int unsigned CountOutBits = 9;
  localparam int unsigned PositionBits = 8;

  // Per-cycle commands broadcast to every cell of the row.
  typedef struct packed {
    logic shift_up;  // insert at head: every record moves one place toward the tail
    logic shift_dn;  // remove head: every record moves one place toward the head
    logic load_rd;   // copy each record into its cell's read line register
    logic shift_rd;  // move the read line one cell toward the head
  } cell_ctrl_t;

endpackage

// ===== design/bounded_record_deque.sv =====
// Top level of the bounded record deque: a row of record cells and the sequencer.
// Depends on brd_pkg, brd_cell and brd_ctrl.
// A result word is held in the output register; a read at position
// p > 0 (a tail read uses p = count - 1) first steps the read line p times, one read line step per cycle.
// Throughput: one word per cycle while no such read is in flight and the output does not stall.
// Reset clears the count and control at once; records stay undefined until written.
`timescale 1ns / 1ps

module bounded_record_deque #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned RECORD_BITS = 32,
  localparam int unsigned SW = ((RECORD_BITS + brd_pkg::PositionBits + 7) / 8) * 8,
  localparam int unsigned MW = ((RECORD_BITS + 1 + brd_pkg::CountOutBits + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // Fields from bit 0: element_data, position; zero padded.
  input  logic [SW-1:0] s_axis_tdata,
  // Fields from bit 0: opcode.
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // Fields from bit 0: read_data, accepted, list_count; zero padded.
  output logic [MW-1:0] m_axis_tdata,
  // Fields from bit 0: read_valid.
  output logic [0:0]    m_axis_tuser
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [RECORD_BITS-1:0]           rec;
  logic [brd_pkg::PositionBits-1:0] position;
  brd_pkg::op_e                     opcode;
  brd_pkg::cell_ctrl_t              cell_ctrl;
  logic                             wr_tail;
  logic [CntW-1:0]                  count;
  logic [RECORD_BITS-1:0]           data_w [CAPACITY];
  logic [RECORD_BITS-1:0]           rd_w   [CAPACITY];
  logic [RECORD_BITS-1:0]           read_data;
  logic                             read_valid, accepted;
  logic [brd_pkg::CountOutBits-1:0] list_count;

  assign rec      = s_axis_tdata[RECORD_BITS-1:0];
  assign position = s_axis_tdata[RECORD_BITS+brd_pkg::PositionBits-1:RECORD_BITS];
  assign opcode   = brd_pkg::op_e'(s_axis_tuser);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [RECORD_BITS-1:0] lo_data, hi_data, rd_hi;
    logic                   tail_sel;

    if (i == 0) begin : g_head
      assign lo_data = rec;
    end else begin : g_inner_lo
      assign lo_data = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign hi_data = data_w[i];
      assign rd_hi   = rd_w[i];
    end else begin : g_inner_hi
      assign hi_data = data_w[i+1];
      assign rd_hi   = rd_w[i+1];
    end

    assign tail_sel = wr_tail && (count == CntW'(i));

    brd_cell #(
      .RECORD_BITS(RECORD_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .tail_sel_i(tail_sel),
      .rec_i     (rec),
      .lo_data_i (lo_data),
      .hi_data_i (hi_data),
      .rd_hi_i   (rd_hi),
      .data_o    (data_w[i]),
      .rd_o      (rd_w[i])
    );
  end

  brd_ctrl #(
    .CAPACITY   (CAPACITY),
    .RECORD_BITS(RECORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (opcode),
    .position_i  (position),
    .head_data_i (data_w[0]),
    .rd_head_i   (rd_w[0]),
    .cell_ctrl_o (cell_ctrl),
    .wr_tail_o   (wr_tail),
    .count_o     (count),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .read_data_o (read_data),
    .read_valid_o(read_valid),
    .accepted_o  (accepted),
    .list_count_o(list_count)
  );

  assign m_axis_tdata = MW'({list_count, accepted, read_data});
  assign m_axis_tuser = read_valid;

endmodule

// ===== design/brd_cell.sv =====
// One storage cell of the deque row: a record register and a read line register.
// Depends on brd_pkg for the command struct.
`timescale 1ns / 1ps

module brd_cell #(
  parameter int unsigned RECORD_BITS = 32
) (
  input  logic                    clk_i,
  input  brd_pkg::cell_ctrl_t     ctrl_i,
  input  logic                    tail_sel_i,
  input  logic [RECORD_BITS-1:0]  rec_i,
  input  logic [RECORD_BITS-1:0]  lo_data_i,
  input  logic [RECORD_BITS-1:0]  hi_data_i,
  input  logic [RECORD_BITS-1:0]  rd_hi_i,
  output logic [RECORD_BITS-1:0]  data_o,
  output logic [RECORD_BITS-1:0]  rd_o
);

  logic [RECORD_BITS-1:0] data_q, data_d;
  logic [RECORD_BITS-1:0] rd_q, rd_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      data_d = lo_data_i;
    end else if (ctrl_i.shift_dn) begin
      data_d = hi_data_i;
    end else if (tail_sel_i) begin
      data_d = rec_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (ctrl_i.load_rd) begin
      rd_d = data_q;
    end else if (ctrl_i.shift_rd) begin
      rd_d = rd_hi_i;
    end
  end

  // Records are payload: their contents are meaningless until written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

// ===== design/brd_ctrl.sv =====
// Sequencer of the deque: record count, operation decode, read line stepping
// and the output register. Depends on brd_pkg.
`timescale 1ns / 1ps

module brd_ctrl #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned RECORD_BITS = 32,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned IdxW = $clog2(CAPACITY)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  brd_pkg::op_e                        opcode_i,
  input  logic [brd_pkg::PositionBits-1:0]    position_i,
  input  logic [RECORD_BITS-1:0]              head_data_i,
  input  logic [RECORD_BITS-1:0]              rd_head_i,
  output brd_pkg::cell_ctrl_t                 cell_ctrl_o,
  output logic                                wr_tail_o,
  output logic [CntW-1:0]                     count_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [RECORD_BITS-1:0]              read_data_o,
  output logic                                read_valid_o,
  output logic                                accepted_o,
  output logic [brd_pkg::CountOutBits-1:0]    list_count_o
);

  localparam int unsigned CmpW = (CntW > brd_pkg::PositionBits) ? CntW
                                                                : brd_pkg::PositionBits;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] steps_q, steps;
  logic            out_valid_q;
  logic            pend_valid_q, pend_acc_q;
  logic [RECORD_BITS-1:0] out_data_q;
  logic            out_rvalid_q, out_acc_q;
  logic [CntW-1:0] out_count_q;

  logic take, full, empty, out_free, op_ok, rvalid, direct, emit_pend;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    op_ok  = 1'b1;
    rvalid = 1'b0;
    steps  = '0;
    unique case (opcode_i)
      brd_pkg::OP_INS_HEAD, brd_pkg::OP_INS_TAIL: op_ok = !full;
      brd_pkg::OP_RM_HEAD, brd_pkg::OP_RM_TAIL:   op_ok = !empty;
      brd_pkg::OP_RD_HEAD: rvalid = !empty;
      brd_pkg::OP_RD_TAIL: begin
        rvalid = !empty;
        if (!empty) begin
          steps = IdxW'(count_q - CntW'(1));
        end
      end
      brd_pkg::OP_RD_INDEX: begin
        rvalid = (CmpW'(position_i) < CmpW'(count_q));
        if (rvalid) begin
          steps = IdxW'(position_i);
        end
      end
      brd_pkg::OP_SIZE: ;
      default: ;
    endcase
  end

  // A result leaves straight from the accepting cycle when no read line
  // stepping is needed and the output register can take it.
  assign direct    = take && (steps == '0) && out_free;
  assign emit_pend = (state_q == ST_BUSY) && (steps_q == '0) && out_free;

  always_comb begin
    count_d     = count_q;
    cell_ctrl_o = '0;
    wr_tail_o   = 1'b0;
    if (take && op_ok) begin
      unique case (opcode_i)
        brd_pkg::OP_INS_HEAD: begin
          count_d              = count_q + CntW'(1);
          cell_ctrl_o.shift_up = 1'b1;
        end
        brd_pkg::OP_INS_TAIL: begin
          count_d   = count_q + CntW'(1);
          wr_tail_o = 1'b1;
        end
        brd_pkg::OP_RM_HEAD: begin
          count_d              = count_q - CntW'(1);
          cell_ctrl_o.shift_dn = 1'b1;
        end
        brd_pkg::OP_RM_TAIL: count_d = count_q - CntW'(1);
        default: ;
      endcase
    end
    cell_ctrl_o.load_rd  = take && rvalid;
    cell_ctrl_o.shift_rd = (state_q == ST_BUSY) && (steps_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (direct || emit_pend) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take && !direct) begin
            steps_q <= steps;
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (steps_q != '0) begin
            steps_q <= steps_q - IdxW'(1);
          end else if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The count travels with the result word, so a later operation cannot
  // change a word that is still waiting at the output.
  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_valid_q <= rvalid;
      pend_acc_q   <= op_ok;
    end
    if (direct) begin
      out_data_q   <= rvalid ? head_data_i : '0;
      out_rvalid_q <= rvalid;
      out_acc_q    <= op_ok;
      out_count_q  <= count_d;
    end else if (emit_pend) begin
      out_data_q   <= pend_valid_q ? rd_head_i : '0;
      out_rvalid_q <= pend_valid_q;
      out_acc_q    <= pend_acc_q;
      out_count_q  <= count_q;
    end
  end

  assign count_o      = count_q;
  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign read_valid_o = out_rvalid_q;
  assign accepted_o   = out_acc_q;
  assign list_count_o = brd_pkg::CountOutBits'(out_count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("record count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !full && (opcode_i == brd_pkg::OP_INS_HEAD || opcode_i == brd_pkg::OP_INS_TAIL))
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted insert did not grow the count");

  a_step_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY && steps_q != '0) |=> steps_q == $past(steps_q) - IdxW'(1))
    else $error("read line step counter did not advance");

  a_busy_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY) |=> count_q == $past(count_q))
    else $error("count changed while an operation was in flight");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");

endmodule
